// ===== rtl/wrp_pkg.sv =====
// ----------------------------------------------------------------------------
// wrp_pkg: shared types and constants of the windowed RMS/peak meter
// Field widths, register indexes and reset values used across the block.
// ----------------------------------------------------------------------------
package wrp_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int MAX_BINS_DEF     = 64;
    localparam int SAMPLE_BITS_DEF  = 24;

    localparam int CH_W   = 3;
    localparam int SPB_W  = 16;
    localparam int NBR_W  = 7;
    localparam int ACT_W  = 4;
    localparam int CFGI_W = 2;
    localparam int CFGD_W = 16;
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;

    typedef enum logic [CFGI_W-1:0] {
        REG_SPB = 2'd0,
        REG_NBW = 2'd1,
        REG_ACT = 2'd2,
        REG_NONE = 2'd3
    } t_reg_idx;

    localparam logic [SPB_W-1:0] SPB_RESET = 16'd800;
    localparam logic [NBR_W-1:0] NBW_RESET = 7'd60;
    localparam logic [ACT_W-1:0] ACT_RESET = 4'd2;

endpackage

// ===== rtl/wrp_if.sv =====
// ----------------------------------------------------------------------------
// wrp_if: item channels of the windowed RMS/peak meter
// Sample input, level output and register write channels.
// ----------------------------------------------------------------------------
interface wrp_in_if #(
    parameter int SAMPLE_BITS = wrp_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [wrp_pkg::CH_W-1:0]      channel;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_end;

    modport source (output valid, channel, sample, frame_end, input ready);
    modport sink   (input valid, channel, sample, frame_end, output ready);
endinterface

interface wrp_out_if #(
    parameter int SAMPLE_BITS = wrp_pkg::SAMPLE_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic [wrp_pkg::CH_W-1:0] out_channel;
    logic [SAMPLE_BITS-1:0]   rms_level;
    logic [SAMPLE_BITS-1:0]   rms_peak_hold;
    logic [SAMPLE_BITS-1:0]   peak_level;
    logic [SAMPLE_BITS-1:0]   peak_hold;
    logic                     last_of_run;

    modport source (output valid, out_channel, rms_level, rms_peak_hold, peak_level,
                    peak_hold, last_of_run, input ready);
    modport sink   (input valid, out_channel, rms_level, rms_peak_hold, peak_level,
                    peak_hold, last_of_run, output ready);
endinterface

interface wrp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [wrp_pkg::CFGI_W-1:0] index;
    logic [wrp_pkg::CFGD_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/wrp_ram.sv =====
// ----------------------------------------------------------------------------
// wrp_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wrp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/wrp_dsq.sv =====
// ----------------------------------------------------------------------------
// wrp_dsq: iterative divide then square root
// Restoring divide, one quotient bit a cycle, then bit-pair square root.
// ----------------------------------------------------------------------------
module wrp_dsq #(
    parameter int DVW = 25
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wrp_pkg::SUM_W-1:0]  i_dividend,
    input  logic [DVW-1:0]             i_divisor,
    output logic                       o_done,
    output logic [wrp_pkg::ROOT_W-1:0] o_root
);
    localparam int SW = wrp_pkg::SUM_W;
    localparam int RW = wrp_pkg::ROOT_W;

    typedef enum logic [2:0] {
        P_IDLE = 3'b001,
        P_DIV  = 3'b010,
        P_SQRT = 3'b100
    } t_phase;

    t_phase          r_ph, n_ph;
    logic [5:0]      r_cnt, n_cnt;
    logic [SW-1:0]   r_q, n_q;
    logic [DVW-1:0]  r_rem, n_rem;
    logic [DVW-1:0]  r_d, n_d;
    logic [RW+1:0]   r_sr, n_sr;
    logic [RW-1:0]   r_root, n_root;
    logic            r_done, n_done;

    logic [DVW:0]    div_sh;
    logic            div_ge;
    logic [RW+3:0]   sq_rem;
    logic [RW+3:0]   sq_trial;
    logic            sq_ge;

    always_comb begin
        div_sh   = {r_rem, r_q[SW-1]};
        div_ge   = div_sh >= {1'b0, r_d};
        sq_rem   = {r_sr, r_q[SW-1:SW-2]};
        sq_trial = {2'b00, r_root, 2'b01};
        sq_ge    = sq_rem >= sq_trial;

        n_ph   = r_ph;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        n_sr   = r_sr;
        n_root = r_root;
        n_done = 1'b0;
        unique case (r_ph)
            P_IDLE: begin
                if (i_start) begin
                    n_q   = i_dividend;
                    n_rem = '0;
                    n_d   = i_divisor;
                    n_cnt = '0;
                    n_ph  = P_DIV;
                end
            end
            P_DIV: begin
                n_rem = div_ge ? DVW'(div_sh - {1'b0, r_d}) : DVW'(div_sh);
                n_q   = {r_q[SW-2:0], div_ge};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_cnt  = '0;
                    n_sr   = '0;
                    n_root = '0;
                    n_ph   = P_SQRT;
                end
            end
            P_SQRT: begin
                n_sr   = sq_ge ? (RW+2)'(sq_rem - sq_trial) : (RW+2)'(sq_rem);
                n_root = {r_root[RW-2:0], sq_ge};
                n_q    = {r_q[SW-3:0], 2'b00};
                n_cnt  = r_cnt + 6'd1;
                if (r_cnt == 6'(RW - 1)) begin
                    n_done = 1'b1;
                    n_ph   = P_IDLE;
                end
            end
            default: n_ph = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= P_IDLE;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_ph   <= n_ph;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_d    <= n_d;
        r_sr   <= n_sr;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ===== rtl/windowed_rms_peak_meter.sv =====
// ----------------------------------------------------------------------------
// windowed_rms_peak_meter: sliding-window RMS and peak level meter
// Per-channel ring of squared-sample bins with RMS, peak and hold readout.
// ----------------------------------------------------------------------------
// One sample item is registered, reads its channel's ring bin, writes back the
// saturated sum and then checks the frame count; the write-back is skipped when
// its channel is not active. The ring lives in a single-port-read RAM. When a
// bin closes, every active channel is reported in turn: the window sum is read
// bin by bin, with a read step and an accumulate step per bin, then one shared
// unit divides by samples_per_bin times bins_in_window and takes the square
// root, and each channel's level may wait on the output. After the last channel
// the new bin is zeroed for every channel. The input is not ready during any of
// this. After reset the ring is cleared in one pass over all
// 2^(clog2(MAX_CHANNELS)+clog2(MAX_BINS)) entries (512 with the defaults) before
// the first item is taken; register writes are taken at any time.
// ----------------------------------------------------------------------------
module windowed_rms_peak_meter #(
    parameter int MAX_CHANNELS = wrp_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_BINS     = wrp_pkg::MAX_BINS_DEF,
    parameter int SAMPLE_BITS  = wrp_pkg::SAMPLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wrp_in_if.sink    i_in,
    wrp_out_if.source o_out,
    wrp_cfg_if.sink   i_cfg
);
    localparam int SB   = SAMPLE_BITS;
    localparam int CW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int BW   = $clog2(MAX_BINS);
    localparam int NBW  = $clog2(MAX_BINS + 1);
    localparam int AW   = CW + BW;
    localparam int DEP  = 1 << AW;
    localparam int DVW  = wrp_pkg::SPB_W + NBW;
    localparam int SW   = wrp_pkg::SUM_W;
    localparam int RW   = wrp_pkg::ROOT_W;
    localparam int CHW  = wrp_pkg::CH_W;
    localparam int CMPW = CW + 4;

    typedef enum logic [9:0] {
        S_CLR     = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_ACC_RD  = 10'b0000000100,
        S_ACC_WR  = 10'b0000001000,
        S_FRAME   = 10'b0000010000,
        S_SUM_RD  = 10'b0000100000,
        S_SUM_ACC = 10'b0001000000,
        S_ROOT    = 10'b0010000000,
        S_EMIT    = 10'b0100000000,
        S_WIPE    = 10'b1000000000
    } t_state;

    t_state r_st, n_st;

    // registers
    logic [wrp_pkg::SPB_W-1:0] r_spb;
    logic [wrp_pkg::NBR_W-1:0] r_nbw;
    logic [wrp_pkg::ACT_W-1:0] r_act;

    // held item
    logic [CHW-1:0]        r_ch;
    logic [SB-1:0]         r_smp;
    logic                  r_fe;
    logic [2*SB-1:0]       r_sq;

    logic [AW-1:0]         r_clr;
    logic [BW-1:0]         r_bp;
    logic [BW-1:0]         r_b;
    logic [CW-1:0]         r_k;
    logic [wrp_pkg::SPB_W-1:0] r_frames;
    logic [SW-1:0]         r_acc;
    logic [DVW-1:0]        r_div;
    logic                  r_go;

    logic [SB-1:0] r_peak  [MAX_CHANNELS];
    logic [SB-1:0] r_rhold [MAX_CHANNELS];
    logic [SB-1:0] r_phold [MAX_CHANNELS];

    // output register
    logic                  r_ov;
    logic [CHW-1:0]        r_o_ch;
    logic [SB-1:0]         r_o_rms;
    logic [SB-1:0]         r_o_rh;
    logic [SB-1:0]         r_o_pk;
    logic [SB-1:0]         r_o_ph;
    logic                  r_o_last;

    // derived
    logic [wrp_pkg::SPB_W-1:0] spb_eff;
    logic [NBW-1:0]        nb_eff;
    logic [CW:0]           nch_eff;
    logic [8:0]            nbw9;
    logic [4:0]            act5;
    logic [CW-1:0]         cha;
    logic                  ch_ok;
    logic [SB-1:0]         mag;
    logic [CW-1:0]         psel;
    logic [SB-1:0]         peak_rd;
    logic [SB-1:0]         rhold_rd;
    logic [SB-1:0]         phold_rd;
    logic                  b_last;
    logic                  k_last;
    logic                  kw_last;
    logic [BW-1:0]         bp_next;
    logic [wrp_pkg::SPB_W-1:0] frames_inc;
    logic                  out_free;
    logic [RW-1:0]         root;
    logic                  dsq_done;
    logic [SB-1:0]         rms;
    logic [SB-1:0]         rhold_new;
    logic [SB-1:0]         phold_new;
    logic [SW:0]           acc_add;
    logic [SW-1:0]         acc_sat;
    logic [SW:0]           bin_add;
    logic [SW-1:0]         bin_sat;

    // RAM ports
    logic                  ram_we;
    logic [AW-1:0]         ram_wa;
    logic [SW-1:0]         ram_wd;
    logic [AW-1:0]         ram_ra;
    logic [SW-1:0]         ram_rd;

    localparam logic [RW-1:0] FULL = RW'(1) << (SB - 1);

    always_comb begin
        spb_eff = (r_spb == '0) ? wrp_pkg::SPB_W'(1) : r_spb;
        nbw9    = 9'(r_nbw);
        nb_eff  = (nbw9 == '0) ? NBW'(1) :
                  (nbw9 > 9'(MAX_BINS)) ? NBW'(MAX_BINS) : NBW'(nbw9);
        act5    = 5'(r_act);
        nch_eff = (act5 == '0) ? (CW+1)'(1) :
                  (act5 > 5'(MAX_CHANNELS)) ? (CW+1)'(MAX_CHANNELS) : (CW+1)'(act5);
        cha     = CW'((CW+CHW)'(r_ch));
        ch_ok   = (CMPW'(r_ch) < CMPW'(nch_eff)) && (CMPW'(r_ch) < CMPW'(MAX_CHANNELS));
        // full negative sample wraps to 2^(SB-1), read as unsigned
        mag     = r_smp[SB-1] ? SB'(~r_smp + SB'(1)) : r_smp;
        psel    = (r_st == S_ACC_RD) ? cha : r_k;
        peak_rd  = r_peak[psel];
        rhold_rd = r_rhold[r_k];
        phold_rd = r_phold[r_k];

        b_last  = ((NBW+1)'(r_b) + (NBW+1)'(1)) == (NBW+1)'(nb_eff);
        k_last  = ((CW+1)'(r_k) + (CW+1)'(1)) == nch_eff;
        kw_last = ((CW+1)'(r_k) + (CW+1)'(1)) == (CW+1)'(MAX_CHANNELS);
        bp_next = (((NBW+1)'(r_bp) + (NBW+1)'(1)) >= (NBW+1)'(nb_eff)) ? '0 :
                  BW'(r_bp + BW'(1));
        frames_inc = (r_frames != '1) ? r_frames + wrp_pkg::SPB_W'(1) : r_frames;

        acc_add = {1'b0, r_acc} + {1'b0, ram_rd};
        acc_sat = acc_add[SW] ? '1 : acc_add[SW-1:0];
        bin_add = {1'b0, ram_rd} + (SW+1)'(r_sq);
        bin_sat = bin_add[SW] ? '1 : bin_add[SW-1:0];

        rms       = (root > FULL) ? SB'(FULL) : SB'(root);
        rhold_new = (rms > rhold_rd) ? rms : rhold_rd;
        phold_new = (peak_rd > phold_rd) ? peak_rd : phold_rd;
        out_free  = !r_ov || o_out.ready;
    end

    // ring RAM access by state
    always_comb begin
        ram_we = 1'b0;
        ram_wa = {cha, r_bp};
        ram_wd = '0;
        ram_ra = {r_k, r_b};
        unique case (r_st)
            S_CLR: begin
                ram_we = 1'b1;
                ram_wa = r_clr;
            end
            S_ACC_WR: begin
                ram_we = 1'b1;
                ram_wd = bin_sat;
            end
            S_WIPE: begin
                ram_we = 1'b1;
                ram_wa = {r_k, r_bp};
            end
            S_ACC_RD: ram_ra = {cha, r_bp};
            default: ram_ra = {r_k, r_b};
        endcase
    end

    // sequencer
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_CLR:     if (r_clr == AW'(DEP - 1)) n_st = S_IDLE;
            S_IDLE:    if (i_in.valid) n_st = S_ACC_RD;
            S_ACC_RD:  n_st = ch_ok ? S_ACC_WR : S_FRAME;
            S_ACC_WR:  n_st = S_FRAME;
            S_FRAME: begin
                if (r_fe && frames_inc >= spb_eff) begin
                    n_st = S_SUM_RD;
                end else begin
                    n_st = S_IDLE;
                end
            end
            S_SUM_RD:  n_st = S_SUM_ACC;
            S_SUM_ACC: n_st = b_last ? S_ROOT : S_SUM_RD;
            S_ROOT:    if (dsq_done) n_st = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_st = k_last ? S_WIPE : S_SUM_RD;
                end
            end
            S_WIPE:    if (kw_last) n_st = S_IDLE;
            default:   n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLR;
            r_spb    <= wrp_pkg::SPB_RESET;
            r_nbw    <= wrp_pkg::NBW_RESET;
            r_act    <= wrp_pkg::ACT_RESET;
            r_clr    <= '0;
            r_bp     <= '0;
            r_b      <= '0;
            r_k      <= '0;
            r_frames <= '0;
            r_go     <= 1'b0;
            r_ov     <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_peak[i]  <= '0;
                r_rhold[i] <= '0;
                r_phold[i] <= '0;
            end
        end else begin
            r_st <= n_st;
            r_go <= 1'b0;

            if (i_cfg.valid) begin
                unique case (wrp_pkg::t_reg_idx'(i_cfg.index))
                    wrp_pkg::REG_SPB: r_spb <= i_cfg.data;
                    wrp_pkg::REG_NBW: r_nbw <= i_cfg.data[wrp_pkg::NBR_W-1:0];
                    wrp_pkg::REG_ACT: r_act <= i_cfg.data[wrp_pkg::ACT_W-1:0];
                    default: ;
                endcase
            end

            // load a new level item, or drop the held one once taken
            if (r_st == S_EMIT && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_st)
                S_CLR: r_clr <= AW'(r_clr + AW'(1));
                S_ACC_RD: begin
                    // track the bin peak while the ring bin is read
                    if (ch_ok && mag > peak_rd) begin
                        r_peak[cha] <= mag;
                    end
                end
                S_FRAME: begin
                    if (r_fe) begin
                        r_frames <= frames_inc;
                    end
                    r_k   <= '0;
                    r_b   <= '0;
                    r_acc <= '0;
                end
                S_SUM_ACC: begin
                    r_acc <= acc_sat;
                    r_b   <= BW'(r_b + BW'(1));
                    if (b_last) begin
                        r_go <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_ch     <= CHW'((CW+CHW)'(r_k));
                        r_o_rms    <= rms;
                        r_o_rh     <= rhold_new;
                        r_o_pk     <= peak_rd;
                        r_o_ph     <= phold_new;
                        r_o_last   <= k_last;
                        r_rhold[r_k] <= rhold_new;
                        r_phold[r_k] <= phold_new;
                        r_b   <= '0;
                        r_acc <= '0;
                        if (k_last) begin
                            // advance the ring and zero the new bin next
                            r_bp <= bp_next;
                            r_k  <= '0;
                        end else begin
                            r_k <= CW'(r_k + CW'(1));
                        end
                    end
                end
                S_WIPE: begin
                    r_k <= CW'(r_k + CW'(1));
                    if (kw_last) begin
                        r_frames <= '0;
                        for (int i = 0; i < MAX_CHANNELS; i++) begin
                            r_peak[i] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end

        // item capture and square, payload only
        if (r_st == S_IDLE && i_in.valid) begin
            r_ch  <= i_in.channel;
            r_smp <= i_in.sample;
            r_fe  <= i_in.frame_end;
        end
        if (r_st == S_ACC_RD) begin
            r_sq <= mag * mag;
        end
        r_div <= DVW'(spb_eff) * DVW'(nb_eff);
    end

    wrp_ram #(
        .WIDTH (SW),
        .DEPTH (DEP)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_raddr (ram_ra),
        .o_rdata (ram_rd)
    );

    wrp_dsq #(
        .DVW (DVW)
    ) u_dsq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go),
        .i_dividend (r_acc),
        .i_divisor  (r_div),
        .o_done     (dsq_done),
        .o_root     (root)
    );

    assign i_in.ready          = (r_st == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_ov;
    assign o_out.out_channel   = r_o_ch;
    assign o_out.rms_level     = r_o_rms;
    assign o_out.rms_peak_hold = r_o_rh;
    assign o_out.peak_level    = r_o_pk;
    assign o_out.peak_hold     = r_o_ph;
    assign o_out.last_of_run   = r_o_last;
endmodule

// ===== tb/sv/tb_windowed_rms_peak_meter.sv =====
// ----------------------------------------------------------------------------
// tb_windowed_rms_peak_meter: regression bench of the windowed RMS/peak meter
// Drives sample items through a directed table and then random frames, predicts
// every level result in a local model of the meter and checks each result
// field by field in arrival order. Registers are changed between phases only.
// ----------------------------------------------------------------------------
module tb_windowed_rms_peak_meter;
    import wrp_pkg::*;

    localparam int NCH    = MAX_CHANNELS_DEF;
    localparam int NBINS  = MAX_BINS_DEF;
    localparam int SBITS  = SAMPLE_BITS_DEF;
    localparam logic [SBITS-1:0] FULL_SCALE = 24'h800000;
    localparam int LIMIT  = 2000000;

    typedef struct packed {
        logic [CH_W-1:0]  chan;
        logic [SBITS-1:0] rms;
        logic [SBITS-1:0] rms_hold;
        logic [SBITS-1:0] peak;
        logic [SBITS-1:0] peak_hold;
        logic             last;
    } t_level;

    // Directed row: sample item plus an optional hard-typed first result.
    typedef struct {
        logic [CH_W-1:0]  chan;
        logic [SBITS-1:0] smp;
        logic             fend;
        logic             has_lit;
        t_level           lit;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    wrp_in_if  in_ch ();
    wrp_out_if out_ch ();
    wrp_cfg_if cfg_ch ();

    windowed_rms_peak_meter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #6 i_clk = ~i_clk;

    // Local copy of the meter state
    logic [63:0]      sums [NCH*NBINS];
    int unsigned      ring_ptr;
    int unsigned      frame_cnt;
    logic [SBITS-1:0] bpeak [NCH];
    logic [SBITS-1:0] rhold [NCH];
    logic [SBITS-1:0] phold [NCH];
    logic [SPB_W-1:0] spb_reg;
    logic [NBR_W-1:0] nbw_reg;
    logic [ACT_W-1:0] act_reg;

    t_level levels_due [$];
    int     errors = 0;
    int     checked = 0;
    int     cycles = 0;
    int     n_items = 0;
    int     send_idle = 29;
    int     recv_idle = 45;

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int unsigned live_chans();
        if (act_reg == 0) return 1;
        if (act_reg > NCH) return NCH;
        return act_reg;
    endfunction

    function automatic int unsigned live_bins();
        if (nbw_reg == 0) return 1;
        if (nbw_reg > NBINS) return NBINS;
        return nbw_reg;
    endfunction

    task automatic clear_model();
        foreach (sums[i]) sums[i] = '0;
        for (int k = 0; k < NCH; k++) begin
            bpeak[k] = '0;
            rhold[k] = '0;
            phold[k] = '0;
        end
        ring_ptr = 0;
        frame_cnt = 0;
        spb_reg = SPB_RESET;
        nbw_reg = NBW_RESET;
        act_reg = ACT_RESET;
    endtask

    // Accumulate one sample; at a bin close queue one level per active channel.
    task automatic meter_sample(logic [CH_W-1:0] ch, logic [SBITS-1:0] raw, logic fend);
        logic [63:0]      mag;
        logic [63:0]      acc;
        logic [63:0]      root;
        int unsigned      nch;
        int unsigned      nb;
        int unsigned      spb;
        t_level           lv;
        nch = live_chans();
        nb  = live_bins();
        spb = (spb_reg == 0) ? 1 : spb_reg;
        mag = raw[SBITS-1] ? (64'd1 << SBITS) - raw : {40'd0, raw};
        if (ch < nch) begin
            sums[ch*NBINS + ring_ptr] = sat_sum(sums[ch*NBINS + ring_ptr], mag * mag);
            if (mag > bpeak[ch]) bpeak[ch] = mag[SBITS-1:0];
        end
        if (!fend) return;
        if (frame_cnt < 16'hFFFF) frame_cnt++;
        if (frame_cnt < spb) return;
        for (int k = 0; k < nch; k++) begin
            acc = 0;
            for (int b = 0; b < nb; b++) acc = sat_sum(acc, sums[k*NBINS + b]);
            root = int_root(acc / (64'(spb) * 64'(nb)));
            if (root > FULL_SCALE) root = FULL_SCALE;
            if (root > rhold[k]) rhold[k] = root[SBITS-1:0];
            if (bpeak[k] > phold[k]) phold[k] = bpeak[k];
            lv.chan      = k[CH_W-1:0];
            lv.rms       = root[SBITS-1:0];
            lv.rms_hold  = rhold[k];
            lv.peak      = bpeak[k];
            lv.peak_hold = phold[k];
            lv.last      = (k + 1 == nch);
            levels_due.push_back(lv);
        end
        ring_ptr = (ring_ptr + 1 >= nb) ? 0 : ring_ptr + 1;
        for (int k = 0; k < NCH; k++) begin
            sums[k*NBINS + ring_ptr] = '0;
            bpeak[k] = '0;
        end
        frame_cnt = 0;
    endtask

    // Drive one sample item and hold it until accepted; valid stays up after
    // the accepting edge until the next item or an idle cycle replaces it.
    task automatic send_sample(logic [CH_W-1:0] ch, logic [SBITS-1:0] raw, logic fend);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.channel   <= ch;
        in_ch.sample    <= raw;
        in_ch.frame_end <= fend;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        meter_sample(ch, raw, fend);
        n_items++;
    endtask

    // Write one register; set_regs drops valid after the last write.
    task automatic write_reg(t_reg_idx idx, logic [CFGD_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            REG_SPB: spb_reg = val;
            REG_NBW: nbw_reg = val[NBR_W-1:0];
            REG_ACT: act_reg = val[ACT_W-1:0];
            default: ;
        endcase
    endtask

    // Drop the input, wait for every queued level, then let the wipe of the new bin finish.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (levels_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [CFGD_W-1:0] spb, logic [CFGD_W-1:0] nb,
                            logic [CFGD_W-1:0] act);
        drain();
        write_reg(REG_SPB, spb);
        write_reg(REG_NBW, nb);
        write_reg(REG_ACT, act);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random frame: one sample per active channel, sometimes an extra or odd one.
    task automatic send_frame();
        int unsigned n;
        logic [SBITS-1:0] v;
        n = live_chans();
        for (int c = 0; c < n; c++) begin
            case ($urandom_range(5))
                0: v = FULL_SCALE;
                1: v = 24'h7FFFFF;
                default: v = SBITS'($urandom);
            endcase
            if ($urandom_range(9) == 0)
                send_sample(CH_W'($urandom_range(7)), SBITS'($urandom), 1'b0);
            send_sample(CH_W'(c), v, c == n - 1);
        end
    endtask

    // Output side: random stall, check each level against the oldest expectation.
    always @(posedge i_clk) begin
        t_level got;
        t_level exp_lv;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.out_channel, out_ch.rms_level, out_ch.rms_peak_hold,
                        out_ch.peak_level, out_ch.peak_hold, out_ch.last_of_run};
                if (levels_due.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected level item: %p", got);
                end else begin
                    exp_lv = levels_due.pop_front();
                    checked++;
                    if (got !== exp_lv) begin
                        errors++;
                        if (errors <= 10)
                            $display("level mismatch: expected %p, got %p", exp_lv, got);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Cycle guard against a hung block.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("windowed_rms_peak_meter regression: fail");
            $finish;
        end
    end

    t_row rows [$];

    initial begin
        in_ch.valid = 1'b0;
        in_ch.channel = '0;
        in_ch.sample = '0;
        in_ch.frame_end = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_SPB;
        cfg_ch.data = '0;
        clear_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One frame per bin, two channels, one bin window.
        set_regs(16'd1, 16'd1, 16'd2);
        // Full negative sample: rms and peak read full scale.
        rows.push_back('{3'd0, FULL_SCALE, 1'b0, 1'b0, '0});
        rows.push_back('{3'd1, 24'h000000, 1'b1, 1'b1,
                         '{3'd0, FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE, 1'b0}});
        // Largest positive sample.
        rows.push_back('{3'd0, 24'h7FFFFF, 1'b0, 1'b0, '0});
        rows.push_back('{3'd1, 24'h000001, 1'b1, 1'b1,
                         '{3'd0, 24'h7FFFFF, FULL_SCALE, 24'h7FFFFF, FULL_SCALE, 1'b0}});
        // Inactive channel: not summed, but its frame mark closes the bin.
        rows.push_back('{3'd7, 24'h7FFFFF, 1'b1, 1'b1,
                         '{3'd0, 24'h0, FULL_SCALE, 24'h0, FULL_SCALE, 1'b0}});
        // Channel sent twice in a frame pushes rms past full scale: clamp.
        rows.push_back('{3'd0, FULL_SCALE, 1'b0, 1'b0, '0});
        rows.push_back('{3'd0, FULL_SCALE, 1'b1, 1'b1,
                         '{3'd0, FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE, 1'b0}});
        rows.push_back('{3'd1, 24'hFFFFFF, 1'b0, 1'b0, '0});
        rows.push_back('{3'd1, 24'h555555, 1'b0, 1'b0, '0});
        rows.push_back('{3'd0, 24'hAAAAAA, 1'b1, 1'b0, '0});
        foreach (rows[i]) begin
            send_sample(rows[i].chan, rows[i].smp, rows[i].fend);
            if (rows[i].has_lit) begin
                // Typed-in first result of this close must agree with the predictor.
                if (levels_due.size() != 0 && levels_due[levels_due.size()-2] !== rows[i].lit)
                    begin
                    errors++;
                    if (errors <= 10)
                        $display("directed row %0d: expected %p", i, rows[i].lit);
                end
            end
        end

        // Frame counter above a lowered bin size; then zero registers act as one.
        set_regs(16'd5, 16'd4, 16'd8);
        repeat (3) send_frame();
        set_regs(16'd2, 16'd4, 16'd8);
        send_frame();
        set_regs(16'd0, 16'd0, 16'd0);
        repeat (3) send_frame();
        // Window grows over stale bins, register values beyond range.
        set_regs(16'd1, 16'd127, 16'd15);
        repeat (2) send_frame();
        set_regs(16'd65535, 16'd64, 16'd1);
        repeat (4) send_frame();
        set_regs(16'd3, 16'd2, 16'd1);

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle = 45;
                recv_idle = 29;
            end else if (ph == 2) begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int r = 0; r < 3; r++) begin
                set_regs(CFGD_W'($urandom_range(1, 3)), CFGD_W'($urandom_range(1, 64)),
                         CFGD_W'($urandom_range(1, 8)));
                repeat (3) send_frame();
            end
        end

        drain();
        $display("sent %0d sample items: directed rows, edge register values and",
                 n_items);
        $display("random frames over 16 register settings and three stall mixes");
        $display("levels checked: %0d, mismatches: %0d", checked, errors);
        if (errors == 0 && levels_due.size() == 0) begin
            $display("windowed_rms_peak_meter regression: pass");
        end else begin
            $display("windowed_rms_peak_meter regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/wrp_pkg.sv
rtl/wrp_if.sv
rtl/wrp_ram.sv
rtl/wrp_dsq.sv
rtl/windowed_rms_peak_meter.sv
tb/sv/tb_windowed_rms_peak_meter.sv
